/* hdl/gbd_pkg.sv */
// Shared types, codes and the CRC step function for the block deframer.
`default_nettype none
package gbd_pkg;

  // Configuration port geometry
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Register index codes (byte address / 4)
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  // Register reset values
  localparam logic [7:0]  SyncFirstRst  = 8'h24;
  localparam logic [7:0]  SyncSecondRst = 8'h40;
  localparam logic [15:0] MaxLenRst     = 16'd4096;

  // Header bytes before the ID field (sync pair and CRC pair)
  localparam int unsigned HdrBeforeId = 4;
  // Offset from body index to total length at the final byte
  localparam logic [16:0] LastOffset  = 17'(HdrBeforeId + 1);
  // Smallest legal total block length
  localparam logic [15:0] MinLen      = 16'd8;

  // CRC-16-CCITT polynomial
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Result status codes
  localparam logic [1:0] ST_ORDINARY = 2'd0;
  localparam logic [1:0] ST_CRC_GOOD = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_ABORT    = 2'd3;

  // Hunt / framing phase, one-hot
  typedef enum logic [4:0] {
    PH_SYNC1  = 5'b00001,
    PH_SYNC2  = 5'b00010,
    PH_CRC_LO = 5'b00100,
    PH_CRC_HI = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  // Configuration register set handed to the core
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_block_length;
  } cfg_t;

  // One byte through the CRC, MSB first, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/gbd_cfg.sv */
// APB-style configuration register file for the block deframer.
`default_nettype none
module gbd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [gbd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [gbd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic      [gbd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                               cfg_pready,
  output gbd_pkg::cfg_t                      cfg
);

  gbd_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first       <= gbd_pkg::SyncFirstRst;
      cfg_r.sync_second      <= gbd_pkg::SyncSecondRst;
      cfg_r.max_block_length <= gbd_pkg::MaxLenRst;
    end else if (wr_en) begin
      case (reg_idx)
        gbd_pkg::REG_SYNC_FIRST:  cfg_r.sync_first       <= cfg_pwdata[7:0];
        gbd_pkg::REG_SYNC_SECOND: cfg_r.sync_second      <= cfg_pwdata[7:0];
        gbd_pkg::REG_MAX_LEN:     cfg_r.max_block_length <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      gbd_pkg::REG_SYNC_FIRST:  cfg_prdata = {24'h0, cfg_r.sync_first};
      gbd_pkg::REG_SYNC_SECOND: cfg_prdata = {24'h0, cfg_r.sync_second};
      gbd_pkg::REG_MAX_LEN:     cfg_prdata = {16'h0, cfg_r.max_block_length};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/gbd_core.sv */
// Input register, framing state, CRC update and result register.
`default_nettype none
module gbd_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gbd_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_data_byte,
  output logic [15:0]        out_byte_index,
  output logic [15:0]        out_block_id,
  output logic [1:0]         out_status,
  output logic               out_is_last
);

  // Input stage
  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  // Framing state
  gbd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] exp_crc_r, exp_crc_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;

  // Result stage
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_idx_r;
  logic [15:0] out_id_r;
  logic [1:0]  out_st_r;
  logic        out_last_r;

  // Result of the byte being worked on
  logic        res_vld;
  logic [1:0]  res_st;
  logic        res_last;
  logic [15:0] res_id;

  logic        out_free;
  logic        proc_go;

  assign out_free = ~out_vld_r | out_ready;
  assign proc_go  = in_vld_r & out_free;
  assign in_ready = ~in_vld_r | proc_go;

  // Input register: refills in the same cycle its byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Per-byte framing decisions
  always_comb begin
    logic [16:0] end_pos;
    end_pos     = {1'b0, seen_r} + gbd_pkg::LastOffset;
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    exp_crc_nxt = exp_crc_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    res_vld     = 1'b0;
    res_st      = gbd_pkg::ST_ORDINARY;
    res_last    = 1'b0;
    res_id      = '0;
    case (phase_r)
      gbd_pkg::PH_SYNC2: begin
        if (in_byte_r == cfg.sync_second) begin
          phase_nxt   = gbd_pkg::PH_CRC_LO;
          crc_nxt     = '0;
          exp_crc_nxt = '0;
          id_nxt      = '0;
          len_nxt     = '0;
          seen_nxt    = '0;
        end else begin
          phase_nxt = gbd_pkg::PH_SYNC1;
        end
      end
      gbd_pkg::PH_CRC_LO: begin
        exp_crc_nxt = {8'h00, in_byte_r};
        phase_nxt   = gbd_pkg::PH_CRC_HI;
      end
      gbd_pkg::PH_CRC_HI: begin
        exp_crc_nxt = {in_byte_r, exp_crc_r[7:0]};
        phase_nxt   = gbd_pkg::PH_BODY;
      end
      gbd_pkg::PH_BODY: begin
        res_vld = 1'b1;
        crc_nxt = gbd_pkg::crc_feed(crc_r, in_byte_r);
        // Header fields inside the body: ID then length, little-endian
        if (seen_r == 16'd0) begin
          id_nxt = {8'h00, in_byte_r};
        end else if (seen_r == 16'd1) begin
          id_nxt = {in_byte_r, id_r[7:0]};
        end else if (seen_r == 16'd2) begin
          len_nxt = {8'h00, in_byte_r};
        end else if (seen_r == 16'd3) begin
          len_nxt = {in_byte_r, len_r[7:0]};
          if (len_nxt < gbd_pkg::MinLen || len_nxt > cfg.max_block_length) begin
            res_st   = gbd_pkg::ST_ABORT;
            res_last = 1'b1;
          end
        end
        // Final byte of the block carries the CRC verdict
        if (!res_last && seen_r >= 16'd3 && end_pos >= {1'b0, len_nxt}) begin
          res_st   = (crc_nxt == exp_crc_r) ? gbd_pkg::ST_CRC_GOOD : gbd_pkg::ST_CRC_BAD;
          res_last = 1'b1;
        end
        res_id = (seen_r == 16'd0) ? 16'd0 : id_nxt;
        if (res_last) begin
          phase_nxt = gbd_pkg::PH_SYNC1;
          seen_nxt  = '0;
        end else begin
          seen_nxt = seen_r + 16'd1;
        end
      end
      default: begin
        phase_nxt = (in_byte_r == cfg.sync_first) ? gbd_pkg::PH_SYNC2 : gbd_pkg::PH_SYNC1;
      end
    endcase
  end

  // Framing state advances once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= gbd_pkg::PH_SYNC1;
      crc_r     <= '0;
      exp_crc_r <= '0;
      id_r      <= '0;
      len_r     <= '0;
      seen_r    <= '0;
    end else if (proc_go) begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      exp_crc_r <= exp_crc_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc_go & res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_vld) begin
      out_byte_r <= in_byte_r;
      out_idx_r  <= seen_r;
      out_id_r   <= res_id;
      out_st_r   <= res_st;
      out_last_r <= res_last;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_data_byte  = out_byte_r;
  assign out_byte_index = out_idx_r;
  assign out_block_id   = out_id_r;
  assign out_status     = out_st_r;
  assign out_is_last    = out_last_r;

endmodule
`default_nettype wire

/* hdl/gnss_block_deframer_crc16.sv */
// Top level of the sync-word block deframer with CRC-16 check.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------------------
//  in_      | sink      | in_valid / in_ready   | in_rx_byte
//  out_     | source    | out_valid / out_ready | out_data_byte, out_byte_index,
//           |           |                       | out_block_id, out_status, out_is_last
//  cfg_     | slave     | psel/penable, pready  | cfg_paddr, cfg_pwdata, cfg_prdata
//
// One byte per cycle is sustained while the output is not stalled; a byte is held in the input
// register and its result is then registered in the result register.
// The CRC update and framing decision are a single byte-wide step between the two.
// rst_n is synchronous: both stages empty, hunt for the first sync byte, registers
// at their defaults. A stalled output holds its result; the input register still
// takes a byte while it is empty or the result register is free or being emptied.
`default_nettype none
module gnss_block_deframer_crc16 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_data_byte,
  output logic [15:0]                        out_byte_index,
  output logic [15:0]                        out_block_id,
  output logic [1:0]                         out_status,
  output logic                               out_is_last,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [gbd_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [gbd_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic      [gbd_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                               cfg_pready
);

  gbd_pkg::cfg_t cfg;

  // Configuration registers
  gbd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Framing datapath
  gbd_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_block_id   (out_block_id),
    .out_status     (out_status),
    .out_is_last    (out_is_last)
  );

endmodule
`default_nettype wire

/* hdl/gbd_checker.sv */
// Port-level assertions for the deframer, bound to the top level.
`default_nettype none
module gbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_data_byte,
  input wire logic [15:0] out_byte_index,
  input wire logic [15:0] out_block_id,
  input wire logic [1:0]  out_status,
  input wire logic        out_is_last
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_byte_index) && $stable(out_block_id) && $stable(out_status) &&
      $stable(out_is_last))
    else $error("result changed while stalled");

  // Only final results carry a non-ordinary status
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last == (out_status != gbd_pkg::ST_ORDINARY)))
    else $error("status and last flag disagree");

  // First body byte has no ID yet and never ends a block
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == 16'd0 |-> out_block_id == 16'd0 && !out_is_last)
    else $error("bad first body byte");

  // A verdict or abort needs the full length field
  a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_byte_index >= 16'd3)
    else $error("block ended before length field");

endmodule

bind gnss_block_deframer_crc16 gbd_checker u_gbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_data_byte  (out_data_byte),
  .out_byte_index (out_byte_index),
  .out_block_id   (out_block_id),
  .out_status     (out_status),
  .out_is_last    (out_is_last)
);
`default_nettype wire
